// File: hdl/mip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_pkg
// Shared types, widths and constants of the multichannel incremental PI core.
// ----------------------------------------------------------------------------
package mip_pkg;

	localparam int NUM_CHANNELS_DEF = 16;

	localparam int CH_W   = 4;
	localparam int DATA_W = 16;
	localparam int ERR_W  = 17;
	localparam int GSUM_W = 17;
	localparam int PROD_W = 33;
	localparam int CFG_IDX_W = 8;

	// floor(m / 1000) = floor(floor(m / 8) / 125), and the division by 125 of a
	// 30-bit value is exact as a multiply by ceil(2^37 / 125) and a shift by 37
	localparam int PRE_SHIFT   = 3;
	localparam int DIVN_W      = PROD_W - PRE_SHIFT;
	localparam int RECIP_W     = 31;
	localparam int RECIP_SHIFT = 37;
	localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;
	localparam int RPROD_W     = DIVN_W + RECIP_W;
	localparam int QUOT_W      = RPROD_W - RECIP_SHIFT;
	localparam int SUM_W       = 27;

	localparam logic [DATA_W-1:0] PROP_GAIN_RST  = 16'd0;
	localparam logic [DATA_W-1:0] INTEG_GAIN_RST = 16'd0;
	localparam logic [DATA_W-1:0] MIN_OUT_RST    = 16'd0;
	localparam logic [DATA_W-1:0] MAX_OUT_RST    = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN  = 8'd0,
		CFG_INTEG_GAIN = 8'd1,
		CFG_MIN_OUT    = 8'd2,
		CFG_MAX_OUT    = 8'd3
	} cfg_idx_t;

endpackage

// File: hdl/mip_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mip_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read during write returns the old word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/multichannel_incremental_pi_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_incremental_pi_core
// Velocity-form PI regulator with per-channel error and output state.
// ----------------------------------------------------------------------------
// The core takes one request per clock when the output side does not stall,
// and returns one result per request, in order. The pipeline has four stages:
// error and previous-error lookup, gain products, division by 1000 as a
// reciprocal multiply, then the add and clamp against the previous output.
// Each channel's state lives in two small RAMs with forwarding between
// neighboring requests, so requests on the same channel can follow each other
// back to back. Reset takes effect at once through per-channel valid bits;
// there is no clearing pass. The user writes gains and clamps through the
// configuration channel while the core is idle; the core does not check it.
// ----------------------------------------------------------------------------
module multichannel_incremental_pi_core
	import mip_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CH_W-1:0]      channel,
	input  logic [DATA_W-1:0]    setpoint,
	input  logic [DATA_W-1:0]    measured,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CH_W-1:0]      out_channel,
	output logic [DATA_W-1:0]    duty,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int EW = (AW > CH_W) ? AW : CH_W;

	// configuration
	logic [DATA_W-1:0] prop_gain_q, integ_gain_q, min_out_q, max_out_q;
	logic [GSUM_W-1:0] gsum;

	// handshake
	logic v1_s1, v2_s2, v3_s3, out_v_q;
	logic rdy1, rdy2, rdy3, adv_out, in_acc;

	// stage 1
	logic [CH_W-1:0]         ch_s1;
	logic                    zero_s1, rng_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic                    pe_vld_s1, pe_fwd_s1;
	logic signed [ERR_W-1:0] pe_fval_s1;
	logic [ERR_W-1:0]        pe_rdata;
	logic signed [ERR_W-1:0] pe_cur;
	logic [ERR_W-1:0]        err_mag, pe_mag;
	logic signed [ERR_W-1:0] pe_wdata;
	logic                    pe_we;

	// stage 2
	logic [CH_W-1:0]   ch_s2;
	logic              zero_s2, rng_s2, neg1_s2, neg2_s2;
	logic [PROD_W-1:0] p1_s2, p2_s2;
	logic [RPROD_W-1:0] rp1, rp2;

	// stage 3
	logic [CH_W-1:0]   ch_s3;
	logic              zero_s3, rng_s3, neg1_s3, neg2_s3;
	logic [QUOT_W-1:0] q1_s3, q2_s3;
	logic              po_vld_s3, po_fwd_s3;
	logic [DATA_W-1:0] po_fval_s3;
	logic [DATA_W-1:0] po_rdata, po_cur;
	logic              po_we, po_re;
	logic [DATA_W-1:0] clamped, po_wdata;
	logic signed [SUM_W-1:0] sum_y;

	// output register
	logic [CH_W-1:0]   out_channel_q;
	logic [DATA_W-1:0] duty_q;

	// addresses
	logic [EW-1:0] in_ext, s1_ext, s2_ext, s3_ext;
	logic [AW-1:0] in_addr, s1_addr, s2_addr, s3_addr;
	logic          in_rng, s2_rng_ch;

	logic [NUM_CHANNELS-1:0] pe_vld_q, po_vld_q;

	assign in_ext  = EW'(channel);
	assign s1_ext  = EW'(ch_s1);
	assign s2_ext  = EW'(ch_s2);
	assign s3_ext  = EW'(ch_s3);
	assign in_addr = in_ext[AW-1:0];
	assign s1_addr = s1_ext[AW-1:0];
	assign s2_addr = s2_ext[AW-1:0];
	assign s3_addr = s3_ext[AW-1:0];
	assign in_rng    = 32'(channel) < NUM_CHANNELS;
	assign s2_rng_ch = rng_s2;

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			min_out_q    <= MIN_OUT_RST;
			max_out_q    <= MAX_OUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				CFG_INTEG_GAIN: integ_gain_q <= cfg_data;
				CFG_MIN_OUT:    min_out_q    <= cfg_data;
				CFG_MAX_OUT:    max_out_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign gsum = GSUM_W'(prop_gain_q) + GSUM_W'(integ_gain_q);

	// ------------------------------------------------------------------------
	// pipeline flow control
	// ------------------------------------------------------------------------
	assign adv_out  = !out_v_q || out_ready;
	assign rdy3     = !v3_s3 || adv_out;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_ready = rdy1;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (adv_out) out_v_q <= v3_s3;
		end
	end

	// ------------------------------------------------------------------------
	// stage 1: error, previous error lookup
	// ------------------------------------------------------------------------
	assign pe_we    = v1_s1 && rdy2 && rng_s1;
	assign pe_wdata = zero_s1 ? '0 : err_s1;

	mip_ram #(
		.WIDTH (ERR_W),
		.DEPTH (NUM_CHANNELS)
	) u_perr_ram (
		.clk   (clk),
		.we    (pe_we),
		.waddr (s1_addr),
		.wdata (pe_wdata),
		.re    (in_acc),
		.raddr (in_addr),
		.rdata (pe_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_s1      <= channel;
			zero_s1    <= setpoint == '0;
			rng_s1     <= in_rng;
			err_s1     <= $signed({1'b0, setpoint}) - $signed({1'b0, measured});
			pe_vld_s1  <= in_rng && pe_vld_q[in_addr];
			// the request leaving stage 1 writes the RAM at this same edge
			pe_fwd_s1  <= pe_we && (ch_s1 == channel);
			pe_fval_s1 <= pe_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pe_vld_q <= '0;
		end else if (pe_we) begin
			pe_vld_q[s1_addr] <= 1'b1;
		end
	end

	always_comb begin
		if (pe_fwd_s1) begin
			pe_cur = pe_fval_s1;
		end else if (pe_vld_s1) begin
			pe_cur = $signed(pe_rdata);
		end else begin
			pe_cur = '0;
		end
		err_mag = err_s1[ERR_W-1] ? ERR_W'(-err_s1) : ERR_W'(err_s1);
		pe_mag  = pe_cur[ERR_W-1] ? ERR_W'(-pe_cur) : ERR_W'(pe_cur);
	end

	// ------------------------------------------------------------------------
	// stage 2: gain products as sign and magnitude
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy2) begin
			ch_s2   <= ch_s1;
			zero_s2 <= zero_s1;
			rng_s2  <= rng_s1;
			neg1_s2 <= err_s1[ERR_W-1];
			neg2_s2 <= pe_cur[ERR_W-1];
			p1_s2   <= PROD_W'(gsum) * PROD_W'(err_mag);
			p2_s2   <= PROD_W'(prop_gain_q) * PROD_W'(pe_mag);
		end
	end

	// ------------------------------------------------------------------------
	// stage 3: truncating division by 1000, previous output lookup
	// ------------------------------------------------------------------------
	assign rp1   = RPROD_W'(p1_s2[PROD_W-1:PRE_SHIFT]) * RPROD_W'(RECIP_125);
	assign rp2   = RPROD_W'(p2_s2[PROD_W-1:PRE_SHIFT]) * RPROD_W'(RECIP_125);
	assign po_re = v2_s2 && rdy3;
	assign po_we = v3_s3 && adv_out && rng_s3;

	mip_ram #(
		.WIDTH (DATA_W),
		.DEPTH (NUM_CHANNELS)
	) u_pout_ram (
		.clk   (clk),
		.we    (po_we),
		.waddr (s3_addr),
		.wdata (po_wdata),
		.re    (po_re),
		.raddr (s2_addr),
		.rdata (po_rdata)
	);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			ch_s3      <= ch_s2;
			zero_s3    <= zero_s2;
			rng_s3     <= rng_s2;
			neg1_s3    <= neg1_s2;
			neg2_s3    <= neg2_s2;
			q1_s3      <= rp1[RPROD_W-1:RECIP_SHIFT];
			q2_s3      <= rp2[RPROD_W-1:RECIP_SHIFT];
			po_vld_s3  <= s2_rng_ch && po_vld_q[s2_addr];
			po_fwd_s3  <= po_we && (ch_s3 == ch_s2);
			po_fval_s3 <= po_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			po_vld_q <= '0;
		end else if (po_we) begin
			po_vld_q[s3_addr] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// final add and clamp into the output register
	// ------------------------------------------------------------------------
	always_comb begin
		logic signed [SUM_W-1:0] t1, t2, lo, hi;
		t1 = neg1_s3 ? -$signed(SUM_W'(q1_s3)) : $signed(SUM_W'(q1_s3));
		t2 = neg2_s3 ? -$signed(SUM_W'(q2_s3)) : $signed(SUM_W'(q2_s3));
		lo = $signed(SUM_W'(min_out_q));
		hi = $signed(SUM_W'(max_out_q));
		if (po_fwd_s3) begin
			po_cur = po_fval_s3;
		end else if (po_vld_s3) begin
			po_cur = po_rdata;
		end else begin
			po_cur = '0;
		end
		sum_y = t1 + $signed(SUM_W'(po_cur)) - t2;
		// max check wins when the clamps cross
		if (sum_y > hi) begin
			clamped = max_out_q;
		end else if (sum_y < lo) begin
			clamped = min_out_q;
		end else begin
			clamped = sum_y[DATA_W-1:0];
		end
		po_wdata = zero_s3 ? '0 : clamped;
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_channel_q <= ch_s3;
			duty_q        <= (rng_s3 && !zero_s3) ? clamped : '0;
		end
	end

	assign out_valid   = out_v_q;
	assign out_channel = out_channel_q;
	assign duty        = duty_q;

endmodule
